FILE: sv/l0go_pkg.sv
`default_nettype none

package l0go_pkg;

    localparam int DEF_MAX_WIDTH      = 2048;
    localparam int DEF_MAX_HEIGHT     = 2048;
    localparam int RESET_FRAME_WIDTH  = 640;
    localparam int RESET_FRAME_HEIGHT = 480;

    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int S_DATA_W   = 6 * CHAN_W;
    localparam int SIZE_W     = 12;
    localparam int LAMBDA_W   = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;
    localparam int ERR_W      = 40;
    localparam int EDGE_W     = 24;
    localparam int OBJ_W      = 44;
    localparam int SQ_ERR_W   = 18;
    localparam int M_DATA_W   = 112;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [ERR_W-1:0]  ERR_MAX  = '1;
    localparam logic [EDGE_W-1:0] EDGE_MAX = '1;
    localparam logic [OBJ_W-1:0]  OBJ_MAX  = '1;

    // Divisor of the colour error: full-scale channel difference squared.
    localparam int COLOR_FULL_SQ = 255 * 255;

    // Reciprocal ceil(2^72 / 65025); (E * RECIP) >> 56 gives floor(E * 65536 / 65025)
    // exactly for every 40-bit E.
    localparam int RECIP_SHIFT = 56;
    localparam int RECIP_W     = 57;
    localparam logic [72:0] RECIP_FULL =
        ((73'd1 << 72) + 73'(COLOR_FULL_SQ - 1)) / 73'(COLOR_FULL_SQ);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_LAMBDA       = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                frame_end;
        logic [1:0]          edges;
        logic [SQ_ERR_W-1:0] sq_err;
    } queue_entry_t;

    typedef struct packed {
        logic [ERR_W-1:0]  error_sum;
        logic [EDGE_W-1:0] edge_count;
    } result_req_t;

endpackage

`default_nettype wire

FILE: sv/l0_gradient_objective.sv
// Frame energy of a piecewise-flat smoothing, one pixel pair per cycle.
// Input stream s_*: one item per pixel in raster order, carrying the original
// and the smoothed RGB pixel. Result stream m_*: one item after the last pixel
// of each frame, carrying the squared colour error, the count of right and down
// neighbour pairs whose smoothed colours differ, and the saturated Q16
// objective floor(error * 65536 / 65025) + lambda * count.
// Configuration port cfg_*: register 0 is the frame width, 1 the frame height
// and 2 the penalty lambda; it is always ready and should be written only while
// no frame is in flight.
// Throughput is one pixel per cycle while s_tready is high, set by the
// single-port line store read and written once per pixel. m_tvalid rises once
// the last pixel of its frame has passed the read stage, the queue, the
// three-stage reciprocal multiplier and the output register.
// After reset the sizes are 640 by 480, lambda is zero and the frame position
// and accumulators are cleared; the line store needs no clearing.
// When the receiver stalls, finished results wait in the output register and
// the objective pipeline, pixels keep being accepted, and s_tready falls only
// once the queue in front of the accumulator has filled.
`default_nettype none

module l0_gradient_objective #(
    parameter int MAX_WIDTH  = l0go_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = l0go_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // orig_red, orig_green, orig_blue, smooth_red, smooth_green, smooth_blue
    input  wire logic [l0go_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // error_sum, edge_count, objective_q16, then zero padding
    output logic [l0go_pkg::M_DATA_W-1:0]        m_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [l0go_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [l0go_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import l0go_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int RST_W = (RESET_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_FRAME_WIDTH;
    localparam int RST_H = (RESET_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_FRAME_HEIGHT;

    logic [COL_W-1:0]    width_last_reg, width_last_next;
    logic [ROW_W-1:0]    height_last_reg, height_last_next;
    logic [LAMBDA_W-1:0] lambda_reg, lambda_next;
    logic [SIZE_W-1:0]   size_wr;
    logic [COL_W-1:0]    width_last_wr;
    logic [ROW_W-1:0]    height_last_wr;
    logic                cfg_fire;

    logic                push, queue_full, q_pop, q_not_empty;
    queue_entry_t        push_entry, q_head;
    logic                res_valid, res_ready;
    result_req_t         res_req;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign size_wr   = cfg_wdata[SIZE_W-1:0];

    // Sizes are stored as their last position; zero acts as one, and sizes
    // beyond MAX_WIDTH or MAX_HEIGHT act as that maximum.
    always_comb begin
        if (size_wr == '0) begin
            width_last_wr = '0;
        end else if (32'(size_wr) > 32'(MAX_WIDTH)) begin
            width_last_wr = COL_W'(MAX_WIDTH - 1);
        end else begin
            width_last_wr = COL_W'(size_wr - 1'b1);
        end
        if (size_wr == '0) begin
            height_last_wr = '0;
        end else if (32'(size_wr) > 32'(MAX_HEIGHT)) begin
            height_last_wr = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            height_last_wr = ROW_W'(size_wr - 1'b1);
        end
    end

    always_comb begin
        width_last_next  = width_last_reg;
        height_last_next = height_last_reg;
        lambda_next      = lambda_reg;
        if (cfg_fire) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_last_next  = width_last_wr;
                CFG_FRAME_HEIGHT: height_last_next = height_last_wr;
                CFG_LAMBDA:       lambda_next      = cfg_wdata[LAMBDA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_last_reg  <= COL_W'(RST_W - 1);
            height_last_reg <= ROW_W'(RST_H - 1);
            lambda_reg      <= '0;
        end else begin
            width_last_reg  <= width_last_next;
            height_last_reg <= height_last_next;
            lambda_reg      <= lambda_next;
        end
    end

    l0go_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .width_last  (width_last_reg),
        .height_last (height_last_reg),
        .push        (push),
        .push_entry  (push_entry),
        .queue_full  (queue_full)
    );

    l0go_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    l0go_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .res_ready   (res_ready),
        .res_valid   (res_valid),
        .res_req     (res_req)
    );

    l0go_objective u_objective (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (res_valid),
        .req_ready  (res_ready),
        .req        (res_req),
        .lambda_q16 (lambda_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

FILE: sv/l0go_front.sv
`default_nettype none

module l0go_front #(
    parameter int  MAX_WIDTH  = l0go_pkg::DEF_MAX_WIDTH,
    parameter int  MAX_HEIGHT = l0go_pkg::DEF_MAX_HEIGHT,
    localparam int COL_W      = $clog2(MAX_WIDTH),
    localparam int ROW_W      = $clog2(MAX_HEIGHT)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [l0go_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic [COL_W-1:0]              width_last,
    input  wire logic [ROW_W-1:0]              height_last,
    output logic                               push,
    output l0go_pkg::queue_entry_t             push_entry,
    input  wire logic                          queue_full
);
    import l0go_pkg::*;

    logic [PIX_W-1:0]  row_mem [MAX_WIDTH];
    logic [PIX_W-1:0]  row_rd_reg;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [PIX_W-1:0]  left_reg, left_next;

    logic              s1_valid_reg, s1_valid_next;
    logic [CHAN_W-1:0] s1_diff_reg [3];
    logic [PIX_W-1:0]  s1_pix_reg;
    logic              s1_up_check_reg;
    logic              s1_left_diff_reg;
    logic              s1_frame_end_reg;

    logic              s_fire;
    logic [PIX_W-1:0]  pix;
    logic [CHAN_W-1:0] diff [3];
    logic              last_col, last_row;
    logic [15:0]       sq [3];
    logic              up_diff;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = !s1_valid_reg || !queue_full;
    assign pix      = s_tdata[S_DATA_W-1:PIX_W];
    assign last_col = col_reg >= width_last;
    assign last_row = row_reg >= height_last;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (s_tdata[i*CHAN_W +: CHAN_W] > s_tdata[PIX_W + i*CHAN_W +: CHAN_W]) begin
                diff[i] = s_tdata[i*CHAN_W +: CHAN_W] - s_tdata[PIX_W + i*CHAN_W +: CHAN_W];
            end else begin
                diff[i] = s_tdata[PIX_W + i*CHAN_W +: CHAN_W] - s_tdata[i*CHAN_W +: CHAN_W];
            end
        end
    end

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (s_fire) begin
            col_next  = last_col ? '0 : col_reg + 1'b1;
            left_next = (last_col && last_row) ? '0 : pix;
            if (last_col) begin
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_fire) begin
            s1_valid_next = 1'b1;
        end else if (push) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            left_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            left_reg     <= left_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            row_mem[col_reg] <= pix;
            row_rd_reg       <= row_mem[col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_diff_reg      <= diff;
            s1_pix_reg       <= pix;
            s1_up_check_reg  <= row_reg != '0;
            s1_left_diff_reg <= (col_reg != '0) && (left_reg != pix);
            s1_frame_end_reg <= last_col && last_row;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq[i] = s1_diff_reg[i] * s1_diff_reg[i];
        end
    end

    assign up_diff = s1_up_check_reg && (row_rd_reg != s1_pix_reg);

    assign push                 = s1_valid_reg && !queue_full;
    assign push_entry.frame_end = s1_frame_end_reg;
    assign push_entry.edges     = {1'b0, s1_left_diff_reg} + {1'b0, up_diff};
    assign push_entry.sq_err    = SQ_ERR_W'(sq[0]) + SQ_ERR_W'(sq[1]) + SQ_ERR_W'(sq[2]);

endmodule

`default_nettype wire

FILE: sv/l0go_queue.sv
`default_nettype none

module l0go_queue (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire l0go_pkg::queue_entry_t  push_entry,
    output logic                         full,
    input  wire logic                    pop,
    output logic                         not_empty,
    output l0go_pkg::queue_entry_t       head
);
    import l0go_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t     slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

FILE: sv/l0go_back.sv
`default_nettype none

module l0go_back (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    q_not_empty,
    input  wire l0go_pkg::queue_entry_t  q_head,
    output logic                         q_pop,
    input  wire logic                    res_ready,
    output logic                         res_valid,
    output l0go_pkg::result_req_t        res_req
);
    import l0go_pkg::*;

    logic [ERR_W-1:0]  err_acc_reg, err_acc_next;
    logic [EDGE_W-1:0] edge_acc_reg, edge_acc_next;
    logic [ERR_W:0]    err_sum;
    logic [EDGE_W:0]   edge_sum;
    logic [ERR_W-1:0]  err_sat;
    logic [EDGE_W-1:0] edge_sat;

    assign q_pop = q_not_empty && (!q_head.frame_end || res_ready);

    assign err_sum  = {1'b0, err_acc_reg} + (ERR_W + 1)'(q_head.sq_err);
    assign edge_sum = {1'b0, edge_acc_reg} + (EDGE_W + 1)'(q_head.edges);
    assign err_sat  = err_sum[ERR_W] ? ERR_MAX : err_sum[ERR_W-1:0];
    assign edge_sat = edge_sum[EDGE_W] ? EDGE_MAX : edge_sum[EDGE_W-1:0];

    assign res_valid          = q_pop && q_head.frame_end;
    assign res_req.error_sum  = err_sat;
    assign res_req.edge_count = edge_sat;

    always_comb begin
        err_acc_next  = err_acc_reg;
        edge_acc_next = edge_acc_reg;
        if (q_pop) begin
            err_acc_next  = q_head.frame_end ? '0 : err_sat;
            edge_acc_next = q_head.frame_end ? '0 : edge_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_acc_reg  <= '0;
            edge_acc_reg <= '0;
        end else begin
            err_acc_reg  <= err_acc_next;
            edge_acc_reg <= edge_acc_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/l0go_objective.sv
`default_nettype none

module l0go_objective (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire l0go_pkg::result_req_t         req,
    input  wire logic [l0go_pkg::LAMBDA_W-1:0] lambda_q16,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [l0go_pkg::M_DATA_W-1:0]      m_tdata
);
    import l0go_pkg::*;

    localparam int HALF_E  = ERR_W / 2;
    localparam int M_LO_W  = 29;
    localparam int M_HI_W  = RECIP_W - M_LO_W;
    localparam int PROD_W  = LAMBDA_W + EDGE_W;
    localparam int A_W     = HALF_E + M_LO_W + HALF_E + 1;
    localparam int B_W     = HALF_E + M_HI_W + HALF_E + 1;
    localparam int TOT_W   = B_W + M_LO_W + 1;
    localparam int QUOT_W  = ERR_W + 1;
    localparam int SUM_W   = PROD_W + 1;

    logic                           en;

    logic                           p1_valid_reg;
    logic [HALF_E+M_LO_W-1:0]       p1_ll_reg, p1_hl_reg;
    logic [HALF_E+M_HI_W-1:0]       p1_lh_reg, p1_hh_reg;
    logic [PROD_W-1:0]              p1_pen_reg;
    result_req_t                    p1_req_reg;

    logic                           p2_valid_reg;
    logic [A_W-1:0]                 p2_a_reg, p2_a_next;
    logic [B_W-1:0]                 p2_b_reg, p2_b_next;
    logic [PROD_W-1:0]              p2_pen_reg;
    result_req_t                    p2_req_reg;

    logic                           p3_valid_reg;
    logic [QUOT_W-1:0]              p3_quot_reg, p3_quot_next;
    logic [PROD_W-1:0]              p3_pen_reg;
    result_req_t                    p3_req_reg;
    logic [TOT_W-1:0]               total;

    logic                           out_valid_reg;
    logic [OBJ_W-1:0]               out_obj_reg, out_obj_next;
    result_req_t                    out_req_reg;
    logic [SUM_W-1:0]               obj_sum;

    assign en        = !out_valid_reg || m_tready;
    assign req_ready = en;

    assign p2_a_next = A_W'(p1_ll_reg) + (A_W'(p1_hl_reg) << HALF_E);
    assign p2_b_next = B_W'(p1_lh_reg) + (B_W'(p1_hh_reg) << HALF_E);

    assign total        = TOT_W'(p2_a_reg) + (TOT_W'(p2_b_reg) << M_LO_W);
    assign p3_quot_next = total[RECIP_SHIFT +: QUOT_W];

    assign obj_sum      = SUM_W'(p3_quot_reg) + SUM_W'(p3_pen_reg);
    assign out_obj_next = (obj_sum[SUM_W-1:OBJ_W] != '0) ? OBJ_MAX : obj_sum[OBJ_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg  <= req_valid;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            out_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_ll_reg   <= req.error_sum[HALF_E-1:0] * RECIP[M_LO_W-1:0];
            p1_hl_reg   <= req.error_sum[ERR_W-1:HALF_E] * RECIP[M_LO_W-1:0];
            p1_lh_reg   <= req.error_sum[HALF_E-1:0] * RECIP[RECIP_W-1:M_LO_W];
            p1_hh_reg   <= req.error_sum[ERR_W-1:HALF_E] * RECIP[RECIP_W-1:M_LO_W];
            p1_pen_reg  <= lambda_q16 * req.edge_count;
            p1_req_reg  <= req;
            p2_a_reg    <= p2_a_next;
            p2_b_reg    <= p2_b_next;
            p2_pen_reg  <= p1_pen_reg;
            p2_req_reg  <= p1_req_reg;
            p3_quot_reg <= p3_quot_next;
            p3_pen_reg  <= p2_pen_reg;
            p3_req_reg  <= p2_req_reg;
            out_obj_reg <= out_obj_next;
            out_req_reg <= p3_req_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_DATA_W - ERR_W - EDGE_W - OBJ_W)'(0), out_obj_reg,
                       out_req_reg.edge_count, out_req_reg.error_sum};

endmodule

`default_nettype wire

FILE: sv/l0go_checker.sv
`default_nettype none

module l0go_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [l0go_pkg::M_DATA_W-1:0] m_tdata
);
    import l0go_pkg::*;

    // A held result stays offered until it is taken.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // Reset empties the result pipeline.
    a_reset_no_result: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

    // Reset empties the read stage, so the input side is ready at once.
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready straight after reset");

    // The scaled error alone is never below the raw error, so neither is the objective.
    a_objective_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[ERR_W+EDGE_W +: OBJ_W] >= OBJ_W'(m_tdata[ERR_W-1:0])))
        else $error("objective below error sum");

endmodule

bind l0_gradient_objective l0go_checker u_l0go_checker (.*);

`default_nettype wire
